// ===== sv/dp_link_training_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_top_macros.svh
// Assertion shorthands for the link training sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef DP_LINK_TRAINING_SEQUENCER_TOP_MACROS_SVH
`define DP_LINK_TRAINING_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, clocked on aclk, held off during reset.
`define DPLT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dplt check failed");

// Next-cycle implication, clocked on aclk, held off during reset.
`define DPLT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dplt check failed");

`endif

// ===== sv/dplt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplt_pkg
// Shared types, constants and helpers for the link training sequencer.
// ----------------------------------------------------------------------------
package dplt_pkg;

    localparam int MAX_LANES = 4;
    localparam int TRY_LIMIT = 5;

    localparam logic [2:0] CNT_SAT   = 3'd7;
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [1:0] RATE_MAX  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_LANE_COUNT = 2'd0;
    localparam logic [1:0] REG_START_RATE = 2'd1;
    localparam logic [1:0] REG_TPS3       = 2'd2;

    typedef enum logic [2:0] {
        ACT_START_CR = 3'd0,
        ACT_ADJUST   = 3'd1,
        ACT_START_EQ = 3'd2,
        ACT_TRAINED  = 3'd3,
        ACT_FAILED   = 3'd4,
        ACT_IGNORED  = 3'd5
    } action_t;

    typedef struct packed {
        logic [2:0] lane_count;
        logic [1:0] start_rate;
        logic       tps3;
    } cfg_t;

    typedef struct packed {
        logic                     kind;
        logic                     aux_ok;
        logic [MAX_LANES-1:0]     cr_done_lanes;
        logic [MAX_LANES-1:0]     eq_lock_lanes;
        logic                     interlane_aligned;
        logic [2*MAX_LANES-1:0]   swing_requests;
        logic [2*MAX_LANES-1:0]   preemph_requests;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] rate_index;
        logic [1:0] pattern;
        logic [5:0] lane_set;
    } result_t;

    // active lane mask; zero lanes counts as one, more than MAX_LANES as MAX_LANES
    function automatic logic [MAX_LANES-1:0] lane_mask(input logic [2:0] lane_count);
        logic [MAX_LANES-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_LANES; i++) begin
            if (i == 0 || 32'(i) < 32'(lane_count)) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/dplt_levels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplt_levels
// Drive level pick: max requested swing and pre-emphasis over active lanes,
// with swing and pre-emphasis clamps and their max flags.
// ----------------------------------------------------------------------------
module dplt_levels (
    input  logic [dplt_pkg::MAX_LANES-1:0]   lane_mask,
    input  logic [2*dplt_pkg::MAX_LANES-1:0] swing_requests,
    input  logic [2*dplt_pkg::MAX_LANES-1:0] preemph_requests,
    output logic [5:0]                       levels
);
    import dplt_pkg::*;

    logic [1:0] swing_max;
    logic [1:0] pre_max;
    logic [1:0] swing;
    logic [1:0] pre_limit;
    logic [1:0] pre;
    logic       swing_flag;
    logic       pre_flag;

    always_comb begin
        swing_max = 2'd0;
        pre_max   = 2'd0;
        for (int i = 0; i < MAX_LANES; i++) begin
            if (lane_mask[i]) begin
                if (swing_requests[2*i +: 2] > swing_max) begin
                    swing_max = swing_requests[2*i +: 2];
                end
                if (preemph_requests[2*i +: 2] > pre_max) begin
                    pre_max = preemph_requests[2*i +: 2];
                end
            end
        end

        swing_flag = (swing_max >= 2'd2);
        swing      = swing_flag ? 2'd2 : swing_max;

        // pre-emphasis ceiling drops as swing rises
        pre_limit = 2'd3 - swing;
        pre_flag  = (pre_max >= pre_limit);
        pre       = pre_flag ? pre_limit : pre_max;

        levels = {pre_flag, pre, swing_flag, swing};
    end

endmodule

// ===== sv/dplt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplt_seq
// Training phase state machine: one status or start transaction per step,
// updates phase, rate, levels and retry counters, registers the result.
// ----------------------------------------------------------------------------
module dplt_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  dplt_pkg::cfg_t    cfg,
    input  dplt_pkg::item_t   item,
    output dplt_pkg::result_t result
);
    import dplt_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CR   = 2'd1,
        PH_EQ2  = 2'd2,
        PH_EQ3  = 2'd3
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [1:0] rate_reg,   rate_next;
    logic [5:0] levels_reg, levels_next;
    logic [2:0] ssc_reg,    ssc_next;     // tries at the same swing
    logic       msw_reg,    msw_next;     // max swing reached during CR
    logic [2:0] eqa_reg,    eqa_next;     // equalization attempts
    action_t    act_reg,    act_next;
    logic [1:0] pat_reg,    pat_next;

    logic [MAX_LANES-1:0] mask;
    logic [5:0]           adj_levels;
    logic                 cr_ok;
    logic                 eq_ok;
    logic                 fail;
    logic [2:0]           eqa_inc;

    assign mask  = lane_mask(cfg.lane_count);
    assign cr_ok = ((item.cr_done_lanes & mask) == mask);
    assign eq_ok = item.interlane_aligned && ((item.eq_lock_lanes & mask) == mask);
    assign eqa_inc = (eqa_reg < CNT_SAT) ? eqa_reg + 3'd1 : eqa_reg;

    dplt_levels u_levels (
        .lane_mask        (mask),
        .swing_requests   (item.swing_requests),
        .preemph_requests (item.preemph_requests),
        .levels           (adj_levels)
    );

    always_comb begin
        phase_next  = phase_reg;
        rate_next   = rate_reg;
        levels_next = levels_reg;
        ssc_next    = ssc_reg;
        msw_next    = msw_reg;
        eqa_next    = eqa_reg;
        act_next    = ACT_IGNORED;
        pat_next    = 2'd0;
        fail        = 1'b0;

        if (!item.kind) begin
            rate_next   = (cfg.start_rate > RATE_MAX) ? RATE_MAX : cfg.start_rate;
            phase_next  = PH_CR;
            levels_next = 6'd0;
            ssc_next    = CNT_ONE;
            msw_next    = 1'b0;
            eqa_next    = 3'd0;
            act_next    = ACT_START_CR;
            pat_next    = 2'd1;
        end else begin
            unique case (phase_reg)
                PH_CR: begin
                    if (!item.aux_ok) begin
                        fail = 1'b1;
                    end else if (cr_ok) begin
                        phase_next = cfg.tps3 ? PH_EQ3 : PH_EQ2;
                        eqa_next   = 3'd0;
                        act_next   = ACT_START_EQ;
                        pat_next   = cfg.tps3 ? 2'd3 : 2'd2;
                    end else if (ssc_reg >= 3'(TRY_LIMIT) || msw_reg) begin
                        fail = 1'b1;
                    end else begin
                        if (adj_levels[1:0] == levels_reg[1:0]) begin
                            ssc_next = (ssc_reg < CNT_SAT) ? ssc_reg + 3'd1 : ssc_reg;
                        end else begin
                            ssc_next = CNT_ONE;
                        end
                        msw_next    = msw_reg | adj_levels[2];
                        levels_next = adj_levels;
                        act_next    = ACT_ADJUST;
                        pat_next    = 2'd1;
                    end
                end
                PH_EQ2, PH_EQ3: begin
                    if (!item.aux_ok || !cr_ok) begin
                        fail = 1'b1;
                    end else if (eq_ok) begin
                        phase_next = PH_IDLE;
                        act_next   = ACT_TRAINED;
                    end else begin
                        eqa_next = eqa_inc;
                        if (eqa_inc >= 3'(TRY_LIMIT)) begin
                            fail = 1'b1;
                        end else begin
                            levels_next = adj_levels;
                            act_next    = ACT_ADJUST;
                            pat_next    = phase_reg;
                        end
                    end
                end
                PH_IDLE: begin
                    act_next = ACT_IGNORED;
                end
            endcase

            // failed phase: step down one rate and restart CR, or give up
            if (fail) begin
                if (rate_reg != 2'd0) begin
                    rate_next   = rate_reg - 2'd1;
                    phase_next  = PH_CR;
                    levels_next = 6'd0;
                    ssc_next    = CNT_ONE;
                    msw_next    = 1'b0;
                    eqa_next    = 3'd0;
                    act_next    = ACT_START_CR;
                    pat_next    = 2'd1;
                end else begin
                    phase_next = PH_IDLE;
                    act_next   = ACT_FAILED;
                    pat_next   = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            rate_reg   <= 2'd0;
            levels_reg <= 6'd0;
            ssc_reg    <= CNT_ONE;
            msw_reg    <= 1'b0;
            eqa_reg    <= 3'd0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            rate_reg   <= rate_next;
            levels_reg <= levels_next;
            ssc_reg    <= ssc_next;
            msw_reg    <= msw_next;
            eqa_reg    <= eqa_next;
        end
        if (step_en) begin
            act_reg <= act_next;
            pat_reg <= pat_next;
        end
    end

    always_comb begin
        result.action     = act_reg;
        result.rate_index = rate_reg;
        result.pattern    = pat_reg;
        result.lane_set   = levels_reg;
    end

endmodule

// ===== sv/dp_link_training_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_top
// DisplayPort source link training sequencer: start and sink status
// transactions in, one training action with rate, pattern and levels out.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while results are taken and returns exactly
// one result for each: the accepting edge loads the input register, and once
// the result register is free or draining, a later edge runs the phase state
// machine into the result register. Input stalls only while both registers
// are full and the result is not taken. Configuration registers reset to
// four lanes, start rate 5.4 Gbps and pattern 3 support; write them only
// while no transaction is in flight.
// AUX and PHY programming stay outside the block.
module dp_link_training_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_wdata,
    // status input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // aux_ok, cr_done_lanes[3:0], eq_lock_lanes[3:0],
                                   // interlane_aligned, swing_requests[7:0],
                                   // preemph_requests[7:0], zero pad
    input  logic        s_tuser,   // kind
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // rate_index[1:0], pattern[1:0], lane_set[5:0],
                                   // drive_swing[1:0], drive_preemph[1:0], zero pad
    output logic [2:0]  m_tuser    // action
);
    import dplt_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    step;
    result_t result;

    // process the held transaction when the result register is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lane_count <= 3'd4;
            cfg_reg.start_rate <= 2'd2;
            cfg_reg.tps3       <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LANE_COUNT: cfg_reg.lane_count <= cfg_wdata;
                REG_START_RATE: cfg_reg.start_rate <= cfg_wdata[1:0];
                REG_TPS3:       cfg_reg.tps3       <= cfg_wdata[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            item_reg.kind              <= s_tuser;
            item_reg.aux_ok            <= s_tdata[0];
            item_reg.cr_done_lanes     <= s_tdata[4:1];
            item_reg.eq_lock_lanes     <= s_tdata[8:5];
            item_reg.interlane_aligned <= s_tdata[9];
            item_reg.swing_requests    <= s_tdata[17:10];
            item_reg.preemph_requests  <= s_tdata[25:18];
        end
    end

    dplt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result.action;
    assign m_tdata  = {2'b00,
                       result.lane_set[4:3],
                       result.lane_set[1:0],
                       result.lane_set,
                       result.pattern,
                       result.rate_index};

endmodule

// ===== sv/dplt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplt_checker
// Port-level checks for the link training sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dp_link_training_sequencer_top_macros.svh"

module dplt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import dplt_pkg::*;

    logic [18:0] res_word;
    logic [1:0]  res_pattern;
    logic [5:0]  res_lane_set;
    logic [1:0]  res_swing;
    logic [1:0]  res_preemph;
    logic        res_ended;

    assign res_word     = {m_tuser, m_tdata};
    assign res_pattern  = m_tdata[3:2];
    assign res_lane_set = m_tdata[9:4];
    assign res_swing    = m_tdata[11:10];
    assign res_preemph  = m_tdata[13:12];
    assign res_ended    = (m_tuser == ACT_TRAINED) || (m_tuser == ACT_FAILED) ||
                          (m_tuser == ACT_IGNORED);

    // stalled result holds
    `DPLT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(res_word))

    // pattern is off exactly when training has ended or the status was ignored
    `DPLT_ASSERT_NOW(a_pattern_off, m_tvalid, (res_pattern == 2'd0) == res_ended)

    // drive fields mirror the lane set field, swing is clamped below 3
    `DPLT_ASSERT_NOW(a_drive_mirror, m_tvalid, res_swing == res_lane_set[1:0] && res_preemph == res_lane_set[4:3] && res_lane_set[1:0] != 2'd3)

    // a CR start always drives pattern 1 from zero levels
    `DPLT_ASSERT_NOW(a_start_cr, m_tvalid && m_tuser == ACT_START_CR, res_pattern == 2'd1 && res_lane_set == 6'd0)

    // with the result register empty the input side is always open
    `DPLT_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

endmodule

bind dp_link_training_sequencer_top dplt_checker u_dplt_checker (.*);

// ===== sim/dp_link_training_sequencer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_checker
// Watches the config port and both stream channels of the link training
// sequencer. It tracks the training state itself and predicts one action per
// accepted start or status transaction. Each returned result is then compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dp_link_training_sequencer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          errors,
    output int          pending
);
    import dplt_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CR   = 2'd1,
        PH_EQ2  = 2'd2,
        PH_EQ3  = 2'd3
    } train_phase_t;

    localparam logic [1:0] PAT_OFF = 2'd0;
    localparam logic [1:0] PAT_CR  = 2'd1;
    localparam logic       KIND_START = 1'b0;

    typedef struct packed {
        action_t    action;
        logic [1:0] rate;
        logic [1:0] pattern;
        logic [5:0] levels;
    } training_step_t;

    logic [2:0]     lanes_cfg;
    logic [1:0]     rate_cfg;
    logic           tps3_cfg;
    train_phase_t   train_phase;
    logic [1:0]     link_rate;
    logic [5:0]     levels;
    logic [2:0]     same_swing_tries;
    logic           max_swing_hit;
    logic [2:0]     eq_tries;
    training_step_t expected_actions[$];
    int             fail_count;

    function automatic int lanes_in_use(input logic [2:0] lanes);
        if (lanes == 3'd0) begin
            return 1;
        end
        if (lanes > 3'(MAX_LANES)) begin
            return MAX_LANES;
        end
        return int'(lanes);
    endfunction

    function automatic logic [3:0] active_mask(input logic [2:0] lanes);
        return 4'((1 << lanes_in_use(lanes)) - 1);
    endfunction

    // highest request over active lanes, clamped to DP swing/pre-emphasis limits
    function automatic logic [5:0] requested_levels(input logic [2:0] lanes,
                                                    input logic [7:0] sw,
                                                    input logic [7:0] pe);
        int         n;
        int         i;
        logic [1:0] v;
        logic [1:0] p;
        logic [1:0] pmax;
        logic       vflag;
        n = lanes_in_use(lanes);
        v = 2'd0;
        p = 2'd0;
        for (i = 0; i < 4; i++) begin
            if (i < n) begin
                if (sw[2*i +: 2] > v) v = sw[2*i +: 2];
                if (pe[2*i +: 2] > p) p = pe[2*i +: 2];
            end
        end
        vflag = (v >= 2'd2);
        if (vflag) v = 2'd2;
        pmax = 2'd3 - v;
        if (p >= pmax) begin
            return {1'b1, pmax, vflag, v};
        end
        return {1'b0, p, vflag, v};
    endfunction

    function automatic void enter_cr();
        train_phase      = PH_CR;
        levels           = 6'd0;
        same_swing_tries = CNT_ONE;
        max_swing_hit    = 1'b0;
        eq_tries         = 3'd0;
    endfunction

    task automatic fall_back(output action_t act, output logic [1:0] pat);
        if (link_rate != 2'd0) begin
            link_rate = link_rate - 2'd1;
            enter_cr();
            act = ACT_START_CR;
            pat = PAT_CR;
        end else begin
            train_phase = PH_IDLE;
            act = ACT_FAILED;
            pat = PAT_OFF;
        end
    endtask

    task automatic predict_step(input logic kind, input logic [31:0] d,
                                output training_step_t r);
        logic       aux;
        logic [3:0] cr;
        logic [3:0] eq;
        logic [3:0] mask;
        logic       aligned;
        logic [7:0] sw;
        logic [7:0] pe;
        logic [5:0] nl;
        action_t    act;
        logic [1:0] pat;
        aux     = d[0];
        cr      = d[4:1];
        eq      = d[8:5];
        aligned = d[9];
        sw      = d[17:10];
        pe      = d[25:18];
        mask    = active_mask(lanes_cfg);
        pat     = PAT_OFF;
        act     = ACT_IGNORED;
        if (kind == KIND_START) begin
            link_rate = (rate_cfg > RATE_MAX) ? RATE_MAX : rate_cfg;
            enter_cr();
            act = ACT_START_CR;
            pat = PAT_CR;
        end else if (train_phase == PH_CR) begin
            if (!aux) begin
                fall_back(act, pat);
            end else if ((cr & mask) == mask) begin
                train_phase = tps3_cfg ? PH_EQ3 : PH_EQ2;
                eq_tries = 3'd0;
                act = ACT_START_EQ;
                pat = train_phase;
            end else if (same_swing_tries >= 3'(TRY_LIMIT) || max_swing_hit) begin
                fall_back(act, pat);
            end else begin
                nl = requested_levels(lanes_cfg, sw, pe);
                if (nl[1:0] == levels[1:0]) begin
                    if (same_swing_tries < CNT_SAT) same_swing_tries++;
                end else begin
                    same_swing_tries = CNT_ONE;
                end
                if (nl[2]) max_swing_hit = 1'b1;
                levels = nl;
                act = ACT_ADJUST;
                pat = PAT_CR;
            end
        end else if (train_phase == PH_EQ2 || train_phase == PH_EQ3) begin
            if (!aux || (cr & mask) != mask) begin
                fall_back(act, pat);
            end else if (aligned && (eq & mask) == mask) begin
                train_phase = PH_IDLE;
                act = ACT_TRAINED;
                pat = PAT_OFF;
            end else begin
                if (eq_tries < CNT_SAT) eq_tries++;
                if (eq_tries >= 3'(TRY_LIMIT)) begin
                    fall_back(act, pat);
                end else begin
                    levels = requested_levels(lanes_cfg, sw, pe);
                    act = ACT_ADJUST;
                    pat = train_phase;
                end
            end
        end
        r = '{act, link_rate, pat, levels};
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        training_step_t exp_r;
        training_step_t new_r;
        if (!aresetn) begin
            lanes_cfg        = 3'd4;
            rate_cfg         = 2'd2;
            tps3_cfg         = 1'b1;
            train_phase      = PH_IDLE;
            link_rate        = 2'd0;
            levels           = 6'd0;
            same_swing_tries = CNT_ONE;
            max_swing_hit    = 1'b0;
            eq_tries         = 3'd0;
            fail_count       = 0;
            expected_actions.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LANE_COUNT: lanes_cfg = cfg_wdata;
                    REG_START_RATE: rate_cfg  = cfg_wdata[1:0];
                    REG_TPS3:       tps3_cfg  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_actions.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual action %0d",
                             $time, m_tuser);
                    fail_count++;
                end else begin
                    exp_r = expected_actions.pop_front();
                    check_field("action", exp_r.action, m_tuser);
                    check_field("rate_index", exp_r.rate, m_tdata[1:0]);
                    check_field("pattern", exp_r.pattern, m_tdata[3:2]);
                    check_field("lane_set", exp_r.levels, m_tdata[9:4]);
                    check_field("drive_swing", exp_r.levels[1:0], m_tdata[11:10]);
                    check_field("drive_preemph", exp_r.levels[4:3], m_tdata[13:12]);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_step(s_tuser, s_tdata, new_r);
                expected_actions.push_back(new_r);
            end
        end
        pending <= expected_actions.size();
        errors  <= fail_count;
    end

endmodule

// ===== sim/dp_link_training_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_top_tb
// Drives start and sink status transactions into the link training sequencer.
// A directed pass covers the phase transitions, then random training sessions
// run under a range of lane count, start rate and TPS3 settings. Both sides
// throttle at random. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module dp_link_training_sequencer_top_tb;
    import dplt_pkg::*;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam int   PHASE_ITEMS = 100;
    localparam int   NUM_PHASES  = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        quiet     = 1'b0;
    int          errors;
    int          pending;
    int          sent      = 0;

    always #5 aclk = ~aclk;

    dp_link_training_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    dp_link_training_sequencer_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 27);
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL dp_link_training_sequencer_top");
        $finish;
    end

    task automatic send_item(input logic kind, input logic aux, input logic [3:0] cr,
                             input logic [3:0] eq, input logic al,
                             input logic [7:0] sw, input logic [7:0] pe);
        while (!quiet && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, pe, sw, al, eq, cr, aux};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_status(input logic aux, input logic [3:0] cr, input logic [3:0] eq,
                               input logic al, input logic [7:0] sw, input logic [7:0] pe);
        send_item(KIND_STATUS, aux, cr, eq, al, sw, pe);
    endtask

    task automatic send_start();
        send_item(KIND_START, 1'($urandom), 4'($urandom), 4'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    // no transaction in flight once pending drops and the pipeline has flushed
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // start, then a short run of sink reports in one of three flavors:
    // cooperative sink, sink that never finishes clock recovery, or plain random
    task automatic run_session();
        int         style;
        int         len;
        logic [7:0] fixed_sw;
        logic [7:0] fixed_pe;
        logic [7:0] sw;
        logic [7:0] pe;
        logic [3:0] cr;
        logic [3:0] eq;
        logic       aux;
        logic       al;
        style    = $urandom_range(0, 2);
        len      = $urandom_range(1, 14);
        fixed_sw = 8'($urandom) & 8'h55;
        fixed_pe = 8'($urandom);
        send_start();
        repeat (len) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(1'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
                          1'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                aux = ($urandom_range(0, 99) < 95);
                case (style)
                    0:       cr = ($urandom_range(0, 99) < 70) ? 4'hF : 4'($urandom);
                    1:       cr = 4'($urandom) & 4'hE;
                    default: cr = 4'($urandom);
                endcase
                eq = ($urandom_range(0, 99) < 40) ? 4'hF : 4'($urandom);
                al = ($urandom_range(0, 99) < 60);
                if (style == 1) begin
                    sw = fixed_sw;
                    pe = fixed_pe;
                end else begin
                    sw = $urandom_range(0, 1) ? 8'($urandom) : (8'($urandom) & 8'h55);
                    pe = 8'($urandom);
                end
                send_status(aux, cr, eq, al, sw, pe);
            end
        end
    endtask

    initial begin
        int         ph;
        int         phase_start;
        logic [2:0] lanes;
        logic [1:0] rate;
        logic       tps3;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_LANE_COUNT, 3'd4);
        write_reg(REG_START_RATE, 3'd2);
        write_reg(REG_TPS3, 3'd1);

        // directed: four lanes, start at 5.4, pattern 3
        send_status(1'b1, 4'hF, 4'hF, 1'b1, 8'hFF, 8'hFF);   // idle, ignored
        send_start();
        send_status(1'b1, 4'h0, 4'h0, 1'b0, 8'hC0, 8'hC0);   // swing 3 -> clamp + flags
        send_status(1'b1, 4'h0, 4'h0, 1'b0, 8'h00, 8'h00);   // max swing seen -> drop rate
        send_status(1'b0, 4'hF, 4'hF, 1'b1, 8'h00, 8'h00);   // aux failure -> rate 0
        send_status(1'b0, 4'hF, 4'hF, 1'b1, 8'h00, 8'h00);   // aux failure at rate 0
        send_start();
        repeat (4) send_status(1'b1, 4'h7, 4'h0, 1'b0, 8'h00, 8'h02);
        send_status(1'b1, 4'h7, 4'h0, 1'b0, 8'h00, 8'h02);   // same swing limit
        send_status(1'b1, 4'h0, 4'h0, 1'b0, 8'h04, 8'h20);   // swing 1, pre-emph clamp
        send_status(1'b1, 4'hF, 4'h0, 1'b0, 8'h00, 8'h00);   // CR done -> EQ
        send_status(1'b1, 4'hF, 4'hF, 1'b0, 8'h11, 8'h44);   // not aligned
        send_status(1'b1, 4'hF, 4'h7, 1'b1, 8'hAA, 8'h55);   // one lane not locked
        send_status(1'b1, 4'h7, 4'hF, 1'b1, 8'h00, 8'h00);   // lost CR in EQ
        send_status(1'b1, 4'hF, 4'h0, 1'b0, 8'h00, 8'h00);
        send_status(1'b1, 4'hF, 4'hF, 1'b1, 8'h00, 8'h00);   // trained
        send_status(1'b0, 4'h0, 4'h0, 1'b0, 8'h00, 8'h00);   // idle, ignored
        send_start();
        send_status(1'b1, 4'hF, 4'hF, 1'b1, 8'hFF, 8'hFF);
        repeat (5) send_status(1'b1, 4'hF, 4'h0, 1'b1, 8'h55, 8'hAA);   // EQ try limit

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin lanes = 3'd1; rate = 2'd0; tps3 = 1'b0; end
                1: begin lanes = 3'd4; rate = 2'd2; tps3 = 1'b1; end
                2: begin lanes = 3'd0; rate = 2'd3; tps3 = 1'b0; end
                3: begin lanes = 3'd7; rate = 2'd1; tps3 = 1'b1; end
                default: begin
                    lanes = 3'($urandom_range(0, 7));
                    rate  = 2'($urandom_range(0, 3));
                    tps3  = 1'($urandom);
                end
            endcase
            write_reg(REG_LANE_COUNT, lanes);
            write_reg(REG_START_RATE, {1'b0, rate});
            write_reg(REG_TPS3, {2'b00, tps3});
            quiet <= (ph == 5);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS) run_session();
        end

        quiet <= 1'b0;
        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS dp_link_training_sequencer_top");
        end else begin
            $display("FAIL dp_link_training_sequencer_top");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dplt_pkg.sv
sv/dplt_levels.sv
sv/dplt_seq.sv
sv/dp_link_training_sequencer_top.sv
sv/dplt_checker.sv
sim/dp_link_training_sequencer_checker.sv
sim/dp_link_training_sequencer_top_tb.sv
